/* src/adl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adl_pkg
// Shared widths, reset values, register codes and types for the resistor
// ladder keypad decoder with debounce.
// ----------------------------------------------------------------------------
package adl_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int NUM_TARGETS = 4;
    localparam int MV_W        = 12;
    localparam int CNT_W       = 8;
    localparam int BTN_W       = 3;
    localparam int KEY_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    localparam int DEFAULT_STREAK_MAX = 255;

    // Classifier result: a ladder key number, or no key at all.
    localparam logic [KEY_W-1:0] KEY_NONE = 3'd4;

    localparam logic [MV_W-1:0]  RST_MATCH_WINDOW = 12'd250;
    localparam logic [MV_W-1:0]  RST_IDLE_THRESH  = 12'd2900;
    localparam logic [MV_W-1:0]  RST_TARGET_0     = 12'd820;
    localparam logic [MV_W-1:0]  RST_TARGET_1     = 12'd1110;
    localparam logic [MV_W-1:0]  RST_TARGET_2     = 12'd1650;
    localparam logic [MV_W-1:0]  RST_TARGET_3     = 12'd2410;
    localparam logic [CNT_W-1:0] RST_DEBOUNCE     = 8'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MATCH_WINDOW = 3'd0,
        REG_IDLE_THRESH  = 3'd1,
        REG_TARGET_0     = 3'd2,
        REG_TARGET_1     = 3'd3,
        REG_TARGET_2     = 3'd4,
        REG_TARGET_3     = 3'd5,
        REG_DEBOUNCE     = 3'd6
    } cfg_reg_t;

    typedef logic [MV_W-1:0] mv_t;

    // Edge events raised by one poll: one flag and one direction per button.
    typedef struct packed {
        logic [NUM_BUTTONS-1:0] mask;
        logic [NUM_BUTTONS-1:0] press;
    } adl_events_t;

endpackage : adl_pkg
`default_nettype wire

/* src/adc_ladder_button_debouncer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adc_ladder_button_debouncer
// Resistor ladder keypad decoder with a boot button and per-button debounce.
// ----------------------------------------------------------------------------
// One input word is one poll: boot pin level, key line voltage in mV, a read
// status flag and the wake-armed flag. It is taken when in_valid is high and
// in_stall is low, and lands in an input register. Once it is there and the
// event store is free, the voltage is classified, the boot button and (unless
// wake is armed) the ladder buttons are updated, and the resulting edge
// events are loaded into the event store. Each output word is one press or
// release edge; last marks the final edge of its poll. A poll that causes no
// edge produces no output word. A poll passes the input register and then the
// event store before its first edge is presented. Its edges (zero to five)
// wait in the store, which emits one word a cycle while the receiver does not
// stall; a poll with no edges leaves the store empty, so polls can arrive
// every cycle while no edges occur. When the receiver stalls, the current word
// is held unchanged, the store keeps its remaining edges, and once the input
// register is full in_stall is raised. Reset clears all buttons to released
// with zero streaks, empties both stages and loads the default thresholds.
// Configuration writes are expected only while the block is idle.
// ----------------------------------------------------------------------------
module adc_ladder_button_debouncer
#(
    parameter int STREAK_MAX = adl_pkg::DEFAULT_STREAK_MAX
)
(
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire [adl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [adl_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire                             boot_level,
    input  wire [adl_pkg::MV_W-1:0]         key_mv,
    input  wire                             key_read_ok,
    input  wire                             wake_armed,
    output logic                            out_valid,
    input  wire                             out_stall,
    output logic [adl_pkg::BTN_W-1:0]       button,
    output logic                            pressed,
    output logic                            last
);
    import adl_pkg::*;

    // Configuration registers.
    mv_t              window_reg;
    mv_t              idle_reg;
    mv_t              target_reg [NUM_TARGETS];
    logic [CNT_W-1:0] debounce_reg;

    // Input register.
    logic             in_full_reg;
    logic             in_full_next;
    logic             boot_reg;
    mv_t              mv_reg;
    logic             ok_reg;
    logic             armed_reg;

    logic             room;
    logic             advance;
    logic             accept;
    logic [KEY_W-1:0] active_key;
    adl_events_t      events;

    // A poll moves on whenever the event store is free; the input register
    // then accepts a new word in the same cycle.
    assign advance  = in_full_reg && room;
    assign in_stall = in_full_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            boot_reg  <= boot_level;
            mv_reg    <= key_mv;
            ok_reg    <= key_read_ok;
            armed_reg <= wake_armed;
        end
    end

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= RST_MATCH_WINDOW;
            idle_reg      <= RST_IDLE_THRESH;
            target_reg[0] <= RST_TARGET_0;
            target_reg[1] <= RST_TARGET_1;
            target_reg[2] <= RST_TARGET_2;
            target_reg[3] <= RST_TARGET_3;
            debounce_reg  <= RST_DEBOUNCE;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MATCH_WINDOW: window_reg    <= cfg_data[MV_W-1:0];
                REG_IDLE_THRESH:  idle_reg      <= cfg_data[MV_W-1:0];
                REG_TARGET_0:     target_reg[0] <= cfg_data[MV_W-1:0];
                REG_TARGET_1:     target_reg[1] <= cfg_data[MV_W-1:0];
                REG_TARGET_2:     target_reg[2] <= cfg_data[MV_W-1:0];
                REG_TARGET_3:     target_reg[3] <= cfg_data[MV_W-1:0];
                REG_DEBOUNCE:     debounce_reg  <= cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    adl_classify u_classify
    (
        .key_mv       (mv_reg),
        .key_read_ok  (ok_reg),
        .match_window (window_reg),
        .idle_thresh  (idle_reg),
        .targets      (target_reg),
        .active_key   (active_key)
    );

    // The boot pin reads low while pressed.
    adl_debounce
    #(
        .STREAK_MAX (STREAK_MAX)
    )
    u_debounce
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (advance),
        .boot_down  (!boot_reg),
        .wake_armed (armed_reg),
        .active_key (active_key),
        .flip_count (debounce_reg),
        .events     (events)
    );

    adl_event_queue u_event_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .load_events (events),
        .room        (room),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .button      (button),
        .pressed     (pressed),
        .last        (last)
    );

endmodule : adc_ladder_button_debouncer
`default_nettype wire

/* src/adl_classify.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adl_classify
// Matches the key line voltage against the four ladder targets.
// ----------------------------------------------------------------------------
module adl_classify
(
    input  wire adl_pkg::mv_t                  key_mv,
    input  wire                                key_read_ok,
    input  wire adl_pkg::mv_t                  match_window,
    input  wire adl_pkg::mv_t                  idle_thresh,
    input  wire adl_pkg::mv_t                  targets [adl_pkg::NUM_TARGETS],
    output logic [adl_pkg::KEY_W-1:0]          active_key
);
    import adl_pkg::*;

    mv_t                    diff [NUM_TARGETS];
    logic [NUM_TARGETS-1:0] hit;

    always_comb
    begin
        for (int i = 0; i < NUM_TARGETS; i++)
        begin
            diff[i] = (key_mv >= targets[i]) ? (key_mv - targets[i]) : (targets[i] - key_mv);
            hit[i]  = (diff[i] <= match_window);
        end
    end

    // The earliest target in order wins where windows overlap.
    always_comb
    begin
        active_key = KEY_NONE;
        if (key_read_ok && (key_mv < idle_thresh))
        begin
            for (int i = NUM_TARGETS - 1; i >= 0; i--)
            begin
                if (hit[i])
                begin
                    active_key = KEY_W'(i);
                end
            end
        end
    end

endmodule : adl_classify
`default_nettype wire

/* src/adl_debounce.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adl_debounce
// Holds the candidate, streak and stable state of all five buttons and updates
// them once per poll (the ladder keys only when not wake-armed), reporting the edges that result.
// ----------------------------------------------------------------------------
module adl_debounce
#(
    parameter int STREAK_MAX = adl_pkg::DEFAULT_STREAK_MAX
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          update,
    input  wire                          boot_down,
    input  wire                          wake_armed,
    input  wire [adl_pkg::KEY_W-1:0]     active_key,
    input  wire [adl_pkg::CNT_W-1:0]     flip_count,
    output adl_pkg::adl_events_t         events
);
    import adl_pkg::*;

    localparam int STREAK_W = $clog2(STREAK_MAX + 1);

    logic [NUM_BUTTONS-1:0] stable_reg;
    logic [NUM_BUTTONS-1:0] stable_next;
    logic [NUM_BUTTONS-1:0] cand_reg;
    logic [NUM_BUTTONS-1:0] cand_next;
    logic [STREAK_W-1:0]    streak_reg  [NUM_BUTTONS];
    logic [STREAK_W-1:0]    streak_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] sample;
    logic [NUM_BUTTONS-1:0] enable;

    always_comb
    begin
        sample[0] = boot_down;
        enable[0] = update;
        for (int i = 1; i < NUM_BUTTONS; i++)
        begin
            sample[i] = (active_key == KEY_W'(i - 1));
            enable[i] = update && !wake_armed;
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            cand_next[i]   = cand_reg[i];
            streak_next[i] = streak_reg[i];
            stable_next[i] = stable_reg[i];
            events.mask[i]  = 1'b0;
            events.press[i] = sample[i];
            if (enable[i])
            begin
                if (sample[i] == cand_reg[i])
                begin
                    if (streak_reg[i] < STREAK_W'(STREAK_MAX))
                    begin
                        streak_next[i] = streak_reg[i] + STREAK_W'(1);
                    end
                end
                else
                begin
                    cand_next[i]   = sample[i];
                    streak_next[i] = STREAK_W'(1);
                end
                if ((CNT_W'(streak_next[i]) >= flip_count) && (sample[i] != stable_reg[i]))
                begin
                    stable_next[i]  = sample[i];
                    events.mask[i]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg <= '0;
            cand_reg   <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                streak_reg[i] <= '0;
            end
        end
        else
        begin
            stable_reg <= stable_next;
            cand_reg   <= cand_next;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                streak_reg[i] <= streak_next[i];
            end
        end
    end

endmodule : adl_debounce
`default_nettype wire

/* src/adl_event_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adl_event_queue
// Holds the edge events of one poll and hands them out one word a cycle while
// out_stall is low, lowest button first.
// ----------------------------------------------------------------------------
module adl_event_queue
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         load,
    input  wire adl_pkg::adl_events_t   load_events,
    output logic                        room,
    output logic                        out_valid,
    input  wire                         out_stall,
    output logic [adl_pkg::BTN_W-1:0]   button,
    output logic                        pressed,
    output logic                        last
);
    import adl_pkg::*;

    logic [NUM_BUTTONS-1:0] mask_reg;
    logic [NUM_BUTTONS-1:0] mask_next;
    logic [NUM_BUTTONS-1:0] press_reg;
    logic [NUM_BUTTONS-1:0] press_next;
    logic [NUM_BUTTONS-1:0] rest;
    logic                   taken;

    always_comb
    begin
        button = '0;
        for (int i = NUM_BUTTONS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                button = BTN_W'(i);
            end
        end
    end

    assign rest      = mask_reg & (mask_reg - NUM_BUTTONS'(1));
    assign out_valid = |mask_reg;
    assign pressed   = press_reg[button];
    assign last      = (rest == '0);
    assign taken     = out_valid && !out_stall;
    // The store is free when empty or when its final word leaves this cycle.
    assign room      = !out_valid || (last && !out_stall);

    always_comb
    begin
        mask_next  = mask_reg;
        press_next = press_reg;
        if (load)
        begin
            mask_next  = load_events.mask;
            press_next = load_events.press;
        end
        else if (taken)
        begin
            mask_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        press_reg <= press_next;
    end

endmodule : adl_event_queue
`default_nettype wire

/* src/adl_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adl_checker
// Port-level checks on the event output of the keypad decoder.
// ----------------------------------------------------------------------------
module adl_checker
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           out_valid,
    input  wire                           out_stall,
    input  wire [adl_pkg::BTN_W-1:0]      button,
    input  wire                           pressed,
    input  wire                           last
);
    import adl_pkg::*;

    // A stalled word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(button) && $stable(pressed)
                                   && $stable(last))
        else $error("stalled output word changed");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (button < BTN_W'(NUM_BUTTONS)))
        else $error("button number out of range");

    // The edges of one poll follow each other without a gap, in button order.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && (button > $past(button)))
        else $error("edges of one poll not contiguous or not in order");

    // The highest button can only be the final edge of its poll.
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (button == BTN_W'(NUM_BUTTONS - 1)) |-> last)
        else $error("last not set on highest button");

endmodule : adl_checker

bind adc_ladder_button_debouncer adl_checker u_adl_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .button    (button),
    .pressed   (pressed),
    .last      (last)
);
`default_nettype wire
